FILE: hdl/kei_pkg.sv
// Shared constants, types and the easing table function for the keyframe interpolator.
package kei_pkg;

    // Easing table depth and derived widths.
    localparam int EASE_TABLE_SIZE = 256;
    localparam int IDX_W = (EASE_TABLE_SIZE > 1) ? $clog2(EASE_TABLE_SIZE) : 1;
    localparam int FRAC_W = 16;
    localparam int W_W = FRAC_W + 1;
    localparam int DIV_STEPS = FRAC_W;
    localparam int PROD_W = W_W + IDX_W;
    localparam longint unsigned EASE_N3 =
        longint'(EASE_TABLE_SIZE) * longint'(EASE_TABLE_SIZE) * longint'(EASE_TABLE_SIZE);

    // Fixed point one, as a weight and as a Q16.16 component.
    localparam logic [W_W-1:0] ONE_Q16 = 17'h1_0000;
    localparam logic [31:0] ONE_FIX = 32'h0001_0000;

    // Channel group codes.
    localparam logic [1:0] KIND_POSITION = 2'd0;
    localparam logic [1:0] KIND_ROTATION = 2'd1;
    localparam logic [1:0] KIND_SCALE = 2'd2;

    typedef enum logic [1:0] {
        ACC_LINEAR = 2'd0,
        ACC_IN_OUT = 2'd1,
        ACC_IN     = 2'd2,
        ACC_OUT    = 2'd3
    } accel_t;

    // Weight class decided before the divider.
    typedef enum logic [1:0] {
        WC_ZERO = 2'd0,
        WC_ONE  = 2'd1,
        WC_DIV  = 2'd2
    } wcls_t;

    typedef struct packed {
        logic [1:0]         kind;
        accel_t             mode;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
    } comp_t;

    typedef struct packed {
        comp_t       comp;
        logic [31:0] ts;
        logic [31:0] te;
        logic [31:0] tn;
    } item_t;

    typedef struct packed {
        wcls_t                cls;
        logic [31:0]          rem;
        logic [31:0]          sp;
        logic [DIV_STEPS-1:0] quo;
        comp_t                comp;
    } div_t;

    // Smoothstep entry i: floor(i*i*(3N - 2i) * 2^16 / N^3), evaluated at elaboration.
    function automatic logic [15:0] ease_entry(input int unsigned i);
        longint unsigned ii;
        longint unsigned num;
        ii = longint'(i);
        num = ii * ii * (3 * longint'(EASE_TABLE_SIZE) - 2 * ii) * 64'd65536;
        return 16'(num / EASE_N3);
    endfunction

endpackage

FILE: hdl/kei_if.sv
// Channel interfaces for interpolation requests and interpolated results.
interface kei_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  accel_mode;
    logic [31:0] time_start;
    logic [31:0] time_end;
    logic [31:0] time_now;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;

    modport source (
        output valid, kind, accel_mode, time_start, time_end, time_now,
        output start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, kind, accel_mode, time_start, time_end, time_now,
        input  start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );
endinterface

interface kei_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;

    modport source (
        output valid, out_x, out_y, out_z,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z,
        output ready
    );
endinterface

FILE: hdl/keyframe_ease_interpolator.sv
// Top level of the keyframe interpolator with smoothstep easing.
// Pipeline: a request beat passes through the time compare, 16 divider stages,
// two easing and two blend stages before its result is valid.
// Throughput: one beat per cycle; the whole pipeline advances together and
// freezes only while the output register holds a result that is not taken.
// Reset clears every valid bit at once; data registers are not reset.
module keyframe_ease_interpolator
    import kei_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    kei_req_if.sink   req,
    kei_rsp_if.source rsp
);

    // The pipeline moves when the output register is empty or being drained.
    // Stalling freezes every stage, so nothing is dropped or duplicated.
    logic adv;

    item_t          item;
    logic           w_valid;
    logic [W_W-1:0] w_val;
    comp_t          w_comp;

    logic           k_valid;
    logic [W_W-1:0] k1;
    logic [W_W-1:0] k2;
    comp_t          k_comp;

    logic out_valid;

    assign adv = !out_valid || rsp.ready;
    assign req.ready = adv;

    // Gather the request beat into one item.
    always_comb
    begin
        item.comp.kind = req.kind;
        item.comp.mode = accel_t'(req.accel_mode);
        item.comp.sx = req.start_x;
        item.comp.sy = req.start_y;
        item.comp.sz = req.start_z;
        item.comp.ex = req.end_x;
        item.comp.ey = req.end_y;
        item.comp.ez = req.end_z;
        item.ts = req.time_start;
        item.te = req.time_end;
        item.tn = req.time_now;
    end

    // Weight in Q1.16, clamped to [0, 1.0], zero for an empty span.
    kei_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req.valid),
        .in_item   (item),
        .out_valid (w_valid),
        .out_w     (w_val),
        .out_comp  (w_comp)
    );

    // Easing mode turns the weight into start and end blend weights.
    kei_ease u_ease (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (w_valid),
        .in_w      (w_val),
        .in_comp   (w_comp),
        .out_valid (k_valid),
        .out_k1    (k1),
        .out_k2    (k2),
        .out_comp  (k_comp)
    );

    // Per-component blend; its last register is the output register.
    kei_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (k_valid),
        .in_k1     (k1),
        .in_k2     (k2),
        .in_comp   (k_comp),
        .out_valid (out_valid),
        .out_x     (rsp.out_x),
        .out_y     (rsp.out_y),
        .out_z     (rsp.out_z)
    );

    assign rsp.valid = out_valid;

endmodule

FILE: hdl/kei_weight.sv
// Weight path: time differences, sign fold and clamp, then a one bit per stage divider.
module kei_weight
    import kei_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  item_t          in_item,
    output logic           out_valid,
    output logic [W_W-1:0] out_w,
    output comp_t          out_comp
);

    logic               s1_valid_reg;
    logic signed [32:0] num_reg;
    logic signed [32:0] span_reg;
    comp_t              s1_comp_reg;

    logic [32:0] mag_num;
    logic [32:0] mag_span;
    wcls_t       cls_next;

    logic [DIV_STEPS:0] dv_valid_reg;
    div_t               div_reg [DIV_STEPS+1];
    div_t               div_next [DIV_STEPS];
    logic [32:0]        shifted [DIV_STEPS];
    logic [32:0]        trial [DIV_STEPS];

    // Stage one: signed differences against the start time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg <= $signed({1'b0, in_item.tn}) - $signed({1'b0, in_item.ts});
            span_reg <= $signed({1'b0, in_item.te}) - $signed({1'b0, in_item.ts});
            s1_comp_reg <= in_item.comp;
        end
    end

    // Stage two: fold a reversed span onto a positive one and clamp.
    always_comb
    begin
        mag_num = span_reg[32] ? 33'(-num_reg) : 33'(num_reg);
        mag_span = span_reg[32] ? 33'(-span_reg) : 33'(span_reg);
        if (span_reg == '0)
        begin
            cls_next = WC_ZERO;
        end
        else if (mag_num[32] || mag_num == '0)
        begin
            cls_next = WC_ZERO;
        end
        else if (mag_num >= mag_span)
        begin
            cls_next = WC_ONE;
        end
        else
        begin
            cls_next = WC_DIV;
        end
    end

    // Each divider stage doubles the remainder and subtracts the span when it fits.
    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            shifted[k] = {div_reg[k].rem, 1'b0};
            trial[k] = shifted[k] - {1'b0, div_reg[k].sp};
            div_next[k] = div_reg[k];
            if (shifted[k] >= {1'b0, div_reg[k].sp})
            begin
                div_next[k].rem = trial[k][31:0];
                div_next[k].quo = {div_reg[k].quo[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                div_next[k].rem = shifted[k][31:0];
                div_next[k].quo = {div_reg[k].quo[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg <= '0;
        end
        else if (adv)
        begin
            dv_valid_reg <= {dv_valid_reg[DIV_STEPS-1:0], s1_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0].cls <= cls_next;
            div_reg[0].rem <= mag_num[31:0];
            div_reg[0].sp <= mag_span[31:0];
            div_reg[0].quo <= '0;
            div_reg[0].comp <= s1_comp_reg;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                div_reg[k+1] <= div_next[k];
            end
        end
    end

    always_comb
    begin
        unique case (div_reg[DIV_STEPS].cls)
            WC_ONE:  out_w = ONE_Q16;
            WC_DIV:  out_w = {1'b0, div_reg[DIV_STEPS].quo};
            default: out_w = '0;
        endcase
    end

    assign out_valid = dv_valid_reg[DIV_STEPS];
    assign out_comp = div_reg[DIV_STEPS].comp;

    // The remainder stays below the span through the whole divider.
    a_rem_entry: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[0] && div_reg[0].cls == WC_DIV |-> div_reg[0].rem < div_reg[0].sp)
        else $error("divider entry remainder not below span");

    a_rem_exit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_reg[DIV_STEPS].cls == WC_DIV
        |-> div_reg[DIV_STEPS].rem < div_reg[DIV_STEPS].sp)
        else $error("divider exit remainder not below span");

endmodule

FILE: hdl/kei_ease.sv
// Easing: table index from the weight, then smoothstep lookup into the two blend weights.
module kei_ease
    import kei_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  logic [W_W-1:0] in_w,
    input  comp_t          in_comp,
    output logic           out_valid,
    output logic [W_W-1:0] out_k1,
    output logic [W_W-1:0] out_k2,
    output comp_t          out_comp
);

    logic [15:0] ease_rom [EASE_TABLE_SIZE];

    logic [W_W-1:0]    pos;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  idx_next;

    logic             e1_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [W_W-1:0]   w_reg;
    comp_t            e1_comp_reg;

    logic [15:0]    rom_val;
    logic [W_W-1:0] doubled;
    logic [W_W-1:0] clamped;
    logic [W_W-1:0] k1_next;
    logic [W_W-1:0] k2_next;

    logic           k_valid_reg;
    logic [W_W-1:0] k1_reg;
    logic [W_W-1:0] k2_reg;
    comp_t          k_comp_reg;

    for (genvar g = 0; g < EASE_TABLE_SIZE; g++)
    begin : g_rom
        assign ease_rom[g] = ease_entry(g);
    end

    // Ease in and in-out look up the complement of the weight; the half modes
    // use one more bit of shift.
    always_comb
    begin
        if (in_comp.mode == ACC_LINEAR || in_comp.mode == ACC_OUT)
        begin
            pos = in_w;
        end
        else
        begin
            pos = ONE_Q16 - in_w;
        end
        prod = PROD_W'(pos) * PROD_W'(EASE_TABLE_SIZE - 1);
        if (in_comp.mode == ACC_IN || in_comp.mode == ACC_OUT)
        begin
            idx_next = prod[FRAC_W+1 +: IDX_W];
        end
        else
        begin
            idx_next = prod[FRAC_W +: IDX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e1_valid_reg <= in_valid;
            k_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_reg <= idx_next;
            w_reg <= in_w;
            e1_comp_reg <= in_comp;
            k1_reg <= k1_next;
            k2_reg <= k2_next;
            k_comp_reg <= e1_comp_reg;
        end
    end

    always_comb
    begin
        rom_val = ease_rom[idx_reg];
        doubled = {rom_val, 1'b0};
        clamped = (doubled > ONE_Q16) ? ONE_Q16 : doubled;
        unique case (e1_comp_reg.mode)
            ACC_IN_OUT:
            begin
                k1_next = {1'b0, rom_val};
                k2_next = ONE_Q16 - {1'b0, rom_val};
            end
            ACC_IN:
            begin
                k1_next = clamped;
                k2_next = ONE_Q16 - clamped;
            end
            ACC_OUT:
            begin
                k2_next = clamped;
                k1_next = ONE_Q16 - clamped;
            end
            default:
            begin
                k2_next = w_reg;
                k1_next = ONE_Q16 - w_reg;
            end
        endcase
    end

    assign out_valid = k_valid_reg;
    assign out_k1 = k1_reg;
    assign out_k2 = k2_reg;
    assign out_comp = k_comp_reg;

    // The two blend weights always make up exactly one.
    a_k_sum: assert property (@(posedge clk) disable iff (!rst_n)
        k_valid_reg |-> ({1'b0, k1_reg} + {1'b0, k2_reg}) == {1'b0, ONE_Q16})
        else $error("blend weights do not sum to one");

endmodule

FILE: hdl/kei_blend.sv
// Blend: per-lane products of both keyframes, then rounded sum into the output register.
module kei_blend
    import kei_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [W_W-1:0]     in_k1,
    input  logic [W_W-1:0]     in_k2,
    input  comp_t              in_comp,
    output logic               out_valid,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    logic               is_scale;
    logic signed [31:0] op_a [3];
    logic signed [31:0] op_b [3];

    logic               b1_valid_reg;
    logic signed [49:0] pa_reg [3];
    logic signed [49:0] pb_reg [3];
    logic               hold_one_reg;
    logic               b1_scale_reg;

    logic signed [50:0] acc [3];
    logic [31:0]        lane_next [3];

    logic               out_valid_reg;
    logic signed [31:0] lane_reg [3];
    logic               out_scale_reg;

    // Scale items blend z into every lane.
    always_comb
    begin
        is_scale = (in_comp.kind == KIND_SCALE);
        op_a[0] = is_scale ? in_comp.sz : in_comp.sx;
        op_a[1] = is_scale ? in_comp.sz : in_comp.sy;
        op_a[2] = in_comp.sz;
        op_b[0] = is_scale ? in_comp.ez : in_comp.ex;
        op_b[1] = is_scale ? in_comp.ez : in_comp.ey;
        op_b[2] = in_comp.ez;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg <= in_valid;
            out_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= 50'(op_a[i]) * 50'($signed({1'b0, in_k1}));
                pb_reg[i] <= 50'(op_b[i]) * 50'($signed({1'b0, in_k2}));
                lane_reg[i] <= lane_next[i];
            end
            hold_one_reg <= is_scale && in_comp.sx == ONE_FIX && in_comp.ex == ONE_FIX;
            b1_scale_reg <= is_scale;
            out_scale_reg <= b1_scale_reg;
        end
    end

    // Round to nearest with halves upward: add one half and floor by an arithmetic shift.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = 51'(pa_reg[i]) + 51'(pb_reg[i]) + 51'sd32768;
            lane_next[i] = hold_one_reg ? ONE_FIX : acc[i][FRAC_W +: 32];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x = lane_reg[0];
    assign out_y = lane_reg[1];
    assign out_z = lane_reg[2];

    // A scale result carries the same value in all three lanes.
    a_scale_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_scale_reg
        |-> lane_reg[0] == lane_reg[1] && lane_reg[1] == lane_reg[2])
        else $error("scale result lanes differ");

endmodule

FILE: tb/tb_keyframe_ease_interpolator.sv
// Self-checking testbench for the keyframe interpolator: directed corners, then a random stream.
`timescale 1ns / 1ps

module tb_keyframe_ease_interpolator;
    import kei_pkg::*;

    // The channel-group code that the block treats like position and rotation.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // The settle time after the last result exceeds the pipeline depth.
    localparam int SETTLE_CYCLES = 30;

    // This limit is far beyond the length of a correct run, even with the
    // longest sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT = 300000;

    localparam int RANDOM_BEATS = 900;

    // One interpolated result: the three output components.
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pose_t;

    logic clk;
    logic rst_n;

    kei_req_if req_ch();
    kei_rsp_if rsp_ch();

    keyframe_ease_interpolator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Results that the predictor has worked out, oldest first.
    pose_t expected_poses[$];
    pose_t oldest_pose;

    int errors = 0;
    int directed_beats = 0;
    int random_beats = 0;
    int results_checked = 0;
    int cycle_count = 0;

    // While this is set, neither side idles. The random test sets it for one
    // long stretch.
    bit steady = 1'b0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // This is the end weight before easing, in Q1.16 on [0, 1.0]. Both
    // differences are signed, so reversed keyframe times keep the direction
    // of travel. A zero span gives zero. Times at or beyond either keyframe
    // clamp to that end.
    function automatic logic [16:0] blend_weight(input logic [31:0] ts, input logic [31:0] te,
                                                 input logic [31:0] tn);
        longint elapsed;
        longint span;
        elapsed = longint'({32'd0, tn}) - longint'({32'd0, ts});
        span = longint'({32'd0, te}) - longint'({32'd0, ts});
        if (span == 0)
            return '0;
        if (span < 0)
        begin
            span = -span;
            elapsed = -elapsed;
        end
        if (elapsed <= 0)
            return '0;
        if (elapsed >= span)
            return ONE_Q16;
        return 17'((elapsed <<< 16) / span);
    endfunction

    // This is one entry of the smoothstep table: 3t^2 - 2t^3 at t = idx / N,
    // in Q1.16, rounded down. The index saturates at the last entry.
    function automatic logic [16:0] smoothstep_at(input longint unsigned idx);
        longint unsigned n;
        longint unsigned num;
        n = longint'(EASE_TABLE_SIZE);
        if (idx >= n)
            idx = n - 1;
        num = idx * idx * (3 * n - 2 * idx) * 65536;
        return 17'(num / (n * n * n));
    endfunction

    // Full-range lookup. The table index is the floor of (N-1) * p.
    function automatic logic [16:0] ease_full_range(input logic [16:0] p);
        longint unsigned scaled;
        scaled = longint'(EASE_TABLE_SIZE - 1);
        scaled = scaled * 64'(p);
        return smoothstep_at(scaled >> 16);
    endfunction

    // Half-range lookup. It reads the table at p / 2, doubles the entry and
    // clamps it to 1.0. This gives the ease-in and ease-out shapes.
    function automatic logic [16:0] ease_half_range(input logic [16:0] p);
        longint unsigned scaled;
        logic [17:0] doubled;
        scaled = longint'(EASE_TABLE_SIZE - 1);
        scaled = scaled * 64'(p);
        doubled = {smoothstep_at(scaled >> 17), 1'b0};
        return (doubled > ONE_Q16) ? ONE_Q16 : doubled[16:0];
    endfunction

    // This is start*k1 + end*k2 in Q16.16. It rounds to nearest with halves
    // going up. The arithmetic shift gives a floor for negative sums as well.
    function automatic logic signed [31:0] mix_component(input logic signed [31:0] a,
                                                         input logic signed [31:0] b,
                                                         input logic [16:0] k1,
                                                         input logic [16:0] k2);
        longint sa;
        longint sb;
        longint ka;
        longint kb;
        longint sum;
        sa = longint'(a);
        sb = longint'(b);
        ka = longint'(k1);
        kb = longint'(k2);
        sum = sa * ka + sb * kb + 32768;
        return sum[47:16];
    endfunction

    function automatic pose_t predict_pose(input item_t it);
        pose_t p;
        logic [16:0] w;
        logic [16:0] k1;
        logic [16:0] k2;
        logic signed [31:0] v;
        w = blend_weight(it.ts, it.te, it.tn);
        case (it.comp.mode)
            ACC_IN_OUT:
            begin
                k1 = ease_full_range(ONE_Q16 - w);
                k2 = ONE_Q16 - k1;
            end
            ACC_IN:
            begin
                k1 = ease_half_range(ONE_Q16 - w);
                k2 = ONE_Q16 - k1;
            end
            ACC_OUT:
            begin
                k2 = ease_half_range(w);
                k1 = ONE_Q16 - k2;
            end
            default:
            begin
                k2 = w;
                k1 = ONE_Q16 - w;
            end
        endcase
        if (it.comp.kind == KIND_SCALE)
        begin
            // For scale, the x components decide the result. If either one
            // is not exactly 1.0, the z pair feeds all three outputs.
            // Otherwise all three outputs are 1.0.
            if (it.comp.sx != ONE_FIX || it.comp.ex != ONE_FIX)
                v = mix_component(it.comp.sz, it.comp.ez, k1, k2);
            else
                v = ONE_FIX;
            p.x = v;
            p.y = v;
            p.z = v;
        end
        else
        begin
            p.x = mix_component(it.comp.sx, it.comp.ex, k1, k2);
            p.y = mix_component(it.comp.sy, it.comp.ey, k1, k2);
            p.z = mix_component(it.comp.sz, it.comp.ez, k1, k2);
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic item_t build_request(input logic [1:0] kind, input accel_t mode,
                                            input logic [31:0] ts, input logic [31:0] te,
                                            input logic [31:0] tn,
                                            input logic [31:0] sx, input logic [31:0] sy,
                                            input logic [31:0] sz, input logic [31:0] ex,
                                            input logic [31:0] ey, input logic [31:0] ez);
        item_t it;
        it.comp.kind = kind;
        it.comp.mode = mode;
        it.ts = ts;
        it.te = te;
        it.tn = tn;
        it.comp.sx = sx;
        it.comp.sy = sy;
        it.comp.sz = sz;
        it.comp.ex = ex;
        it.comp.ey = ey;
        it.comp.ez = ez;
        return it;
    endfunction

    // Most components are fully random, so every bit toggles. The rest are
    // small values near zero, the two extremes, or exactly 1.0.
    function automatic logic [31:0] random_component();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom;
        else if (sel < 8)
            return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
        else if (sel == 8)
            return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return ONE_FIX;
    endfunction

    function automatic item_t random_request();
        item_t it;
        int sel;
        longint span;
        longint frac;
        sel = $urandom_range(0, 19);
        it.comp.kind = (sel == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
        it.comp.mode = accel_t'($urandom_range(0, 3));
        it.ts = $urandom;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            // The current time falls between the keyframes. Spans come in
            // every magnitude and in both directions.
            span = longint'($urandom >> $urandom_range(0, 31));
            if ($urandom_range(0, 1))
                span = -span;
            frac = longint'($urandom_range(0, 65536));
            it.te = it.ts + 32'(span);
            it.tn = it.ts + 32'((span * frac) >>> 16);
        end
        else if (sel == 7)
        begin
            it.te = it.ts;
            it.tn = $urandom;
        end
        else
        begin
            it.te = $urandom;
            it.tn = $urandom;
        end
        it.comp.sx = random_component();
        it.comp.sy = random_component();
        it.comp.sz = random_component();
        it.comp.ex = random_component();
        it.comp.ey = random_component();
        it.comp.ez = random_component();
        if (it.comp.kind == KIND_SCALE)
        begin
            // For scale, favor x pairs with one or both components exactly 1.0.
            case ($urandom_range(0, 3))
                0:
                begin
                    it.comp.sx = ONE_FIX;
                    it.comp.ex = ONE_FIX;
                end
                1: it.comp.sx = ONE_FIX;
                2: it.comp.ex = ONE_FIX;
                default: ;
            endcase
        end
        return it;
    endfunction

    // This task sends one request beat. A random gap may come first, with
    // valid low. The inputs change only at falling edges. Valid stays high
    // after the beat is taken. The next call, or the caller, lowers it or
    // replaces the payload at a later falling edge.
    task automatic send_request(input item_t it);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 37)
            gap = $urandom_range(1, 3);
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.kind <= it.comp.kind;
        req_ch.accel_mode <= it.comp.mode;
        req_ch.time_start <= it.ts;
        req_ch.time_end <= it.te;
        req_ch.time_now <= it.tn;
        req_ch.start_x <= it.comp.sx;
        req_ch.start_y <= it.comp.sy;
        req_ch.start_z <= it.comp.sz;
        req_ch.end_x <= it.comp.ex;
        req_ch.end_y <= it.comp.ey;
        req_ch.end_z <= it.comp.ez;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_poses.push_back(predict_pose(it));
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // These tests cover how the weight is formed. Linear mode shows the raw
    // weight. The start is -5.0 and the end is 3.0 for every component.
    task automatic test_weight_forms();
        logic [31:0] a;
        logic [31:0] b;
        a = 32'hFFFB_0000;
        b = 32'h0003_0000;
        // Zero span: the weight is zero whatever the current time is.
        send_request(build_request(KIND_POSITION, ACC_LINEAR, 100, 100, 50, a, a, a, b, b, b));
        // The current time is before the start, at the start, halfway,
        // at the end, and far past the end.
        send_request(build_request(KIND_POSITION, ACC_LINEAR, 1000, 2000, 10, a, a, a, b, b, b));
        send_request(build_request(KIND_POSITION, ACC_LINEAR, 1000, 2000, 1000, a, a, a, b, b, b));
        send_request(build_request(KIND_POSITION, ACC_LINEAR, 1000, 2000, 1500, a, a, a, b, b, b));
        send_request(build_request(KIND_POSITION, ACC_LINEAR, 1000, 2000, 2000, a, a, a, b, b, b));
        send_request(build_request(KIND_ROTATION, ACC_LINEAR, 1000, 2000, 32'hFFFF_FFFF,
                                   a, a, a, b, b, b));
        // Reversed keyframe times: the end comes before the start.
        send_request(build_request(KIND_ROTATION, ACC_LINEAR, 2000, 1000, 1250, a, a, a, b, b, b));
        send_request(build_request(KIND_ROTATION, ACC_LINEAR, 2000, 1000, 0, a, a, a, b, b, b));
        // The widest span there is.
        send_request(build_request(KIND_POSITION, ACC_LINEAR, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                   a, a, a, b, b, b));
        directed_beats += 9;
    endtask

    // This test runs every easing mode at one third of the span and one
    // tick before the end. Near the end, the doubled half-range entries come
    // close to the clamp at 1.0 but stay below it.
    task automatic test_easing_modes();
        for (int m = 0; m < 4; m++)
        begin
            send_request(build_request(KIND_POSITION, accel_t'(m), 0, 32'h3_0000, 32'h1_0000,
                                       32'h0000_0000, 32'h0064_0000, 32'hFF9C_0000,
                                       32'h0001_0000, 32'hFF9C_0000, 32'h0064_0000));
            send_request(build_request(KIND_POSITION, accel_t'(m), 0, 32'h3_0000, 32'h2_FFFF,
                                       32'h0000_0000, 32'h0064_0000, 32'hFF9C_0000,
                                       32'h0001_0000, 32'hFF9C_0000, 32'h0064_0000));
        end
        directed_beats += 8;
    endtask

    // This test covers the scale group, where the x pair selects the result,
    // and the spare channel-group code.
    task automatic test_scale_group();
        send_request(build_request(KIND_SCALE, ACC_LINEAR, 0, 100, 40, ONE_FIX, 32'h5_0000,
                                   32'h2_0000, ONE_FIX, 32'h6_0000, 32'h4_0000));
        send_request(build_request(KIND_SCALE, ACC_IN_OUT, 0, 100, 40, 32'h1_0001, 32'h5_0000,
                                   32'h2_0000, ONE_FIX, 32'h6_0000, 32'h4_0000));
        send_request(build_request(KIND_SCALE, ACC_OUT, 0, 100, 40, ONE_FIX, 32'h5_0000,
                                   32'h2_0000, 32'h0_8000, 32'h6_0000, 32'h4_0000));
        send_request(build_request(KIND_SPARE, ACC_IN, 0, 100, 40, ONE_FIX, 32'h5_0000,
                                   32'h2_0000, ONE_FIX, 32'h6_0000, 32'h4_0000));
        directed_beats += 4;
    endtask

    // This test uses full-scale components in both directions and all-zero
    // keyframes.
    task automatic test_component_extremes();
        send_request(build_request(KIND_POSITION, ACC_OUT, 10, 30, 20,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(build_request(KIND_ROTATION, ACC_IN_OUT, 10, 30, 29,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_request(build_request(KIND_POSITION, ACC_IN, 32'hFFFF_FFFF, 0, 32'h8000_0000,
                                   0, 0, 0, 0, 0, 0));
        directed_beats += 3;
    endtask

    // This test sends the random stream. Partway through, the sender stops
    // until every result is back. After that comes a long stretch with no
    // idling on either side.
    task automatic test_random_stream();
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == RANDOM_BEATS / 3)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                while (expected_poses.size() != 0)
                    @(negedge clk);
            end
            steady = (i >= RANDOM_BEATS / 2) && (i < RANDOM_BEATS / 2 + 200);
            send_request(random_request());
            random_beats++;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver stalls at random, with a probability of 37 percent,
    // except in the steady stretch.
    always @(negedge clk)
        rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 37);

    task automatic check_field(input string label, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t ns: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                         $time, label, want, want, got, got);
        end
    endtask

    // Each result beat is compared with the oldest expected pose. The cycle
    // counter also runs here. It ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_poses.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t ns: unexpected result beat, got x=0x%08h y=0x%08h z=0x%08h",
                             $time, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z);
            end
            else
            begin
                oldest_pose = expected_poses.pop_front();
                check_field("out_x", oldest_pose.x, rsp_ch.out_x);
                check_field("out_y", oldest_pose.y, rsp_ch.out_y);
                check_field("out_z", oldest_pose.z, rsp_ch.out_z);
                results_checked++;
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, expected_poses.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = '0;
        req_ch.accel_mode = '0;
        req_ch.time_start = '0;
        req_ch.time_end = '0;
        req_ch.time_now = '0;
        req_ch.start_x = '0;
        req_ch.start_y = '0;
        req_ch.start_z = '0;
        req_ch.end_x = '0;
        req_ch.end_y = '0;
        req_ch.end_z = '0;
        rsp_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_weight_forms();
        test_easing_modes();
        test_scale_group();
        test_component_extremes();
        test_random_stream();

        // Release the last beat and wait for all outstanding results. The
        // settle time afterward catches any extra result beat.
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d directed and %0d random beats over all channel groups and easing modes",
                 directed_beats, random_beats);
        $display("Checked %0d results in %0d cycles, %0d mismatches",
                 results_checked, cycle_count, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
